// ----- rtl/mps_pkg.sv -----
package mps_pkg;

    localparam int DATA_W    = 32;
    localparam int POW_W     = 16;
    localparam int DIMREG_W  = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_DIM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER      = 2'd1;

    localparam logic [DIMREG_W-1:0] DIM_RESET   = 4'd3;
    localparam logic [POW_W-1:0]    POWER_RESET = 16'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_INIT_RD,
        S_INIT_WR,
        S_MUL_RD,
        S_MUL_PROD,
        S_MUL_ACC,
        S_CPY_RD,
        S_CPY_WR,
        S_EMIT_RD,
        S_EMIT_LOAD,
        S_EMIT_HOLD
    } t_state;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic clr;
    } t_mac_ctl;

endpackage

// ----- rtl/mps_ram.sv -----
module mps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- rtl/mps_mac.sv -----
module mps_mac (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mps_pkg::t_mac_ctl     i_ctl,
    input  logic [31:0]           i_a,
    input  logic [31:0]           i_b,
    output logic [31:0]           o_sum
);
    import mps_pkg::*;

    logic [31:0] r_prod;
    logic [31:0] r_acc;
    logic [63:0] w_full;

    assign w_full = i_a * i_b;
    assign o_sum  = r_acc + r_prod;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= w_full[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= i_ctl.clr ? '0 : o_sum;
        end
    end

endmodule

// ----- rtl/matrix_power_by_squaring.sv -----
// Loads a square matrix of matrix_dim rows (row-major, one element per beat) and, on the beat
// marked last_element, raises it to the power register by repeated squaring, wrapping to 32
// bits. Load beats are taken one per cycle; the last beat is taken at once and the input is
// then stalled until the whole result has gone out. Each matrix product uses one shared
// multiplier, with read, product and accumulate states per multiply-accumulate through the
// registered RAM reads, then a copy-back sweep; there are up to 2*log2(power) products. Each
// result beat passes through read, load and hold states, and the next one is read only after
// the last is taken. Power zero gives the identity without any products.
module matrix_power_by_squaring #(
    parameter int MAX_DIM = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [31:0]                i_element_value,
    input  logic                              i_last_element,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [31:0]                o_result_value,
    output logic                              o_result_last,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mps_pkg::POW_W-1:0]         i_cfg_data
);
    import mps_pkg::*;

    localparam int CELLS = MAX_DIM * MAX_DIM;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW    = $clog2(MAX_DIM + 1);
    localparam int LW    = $clog2(CELLS + 1);

    t_state r_state, n_state;

    logic [DIMREG_W-1:0] r_mdim;
    logic [POW_W-1:0]    r_power;
    logic [POW_W-1:0]    r_e;
    logic [3:0]          r_bit, n_bit;
    logic                r_sq, n_sq;
    logic [CW-1:0]       r_i, n_i, r_j, n_j, r_k, n_k;
    logic [LW-1:0]       r_lcnt;
    logic [CW-1:0]       r_lr, r_lc;
    logic [31:0]         r_out_val;
    logic                r_out_last;
    logic                r_out_valid;

    logic [CW-1:0] w_d, w_dm1;
    logic [LW-1:0] w_total;
    logic          w_in_acc, w_out_acc;
    logic          w_last_ij;

    logic          w_base_we, w_pow_we, w_scr_we;
    logic [AW-1:0] w_base_waddr, w_base_raddr, w_pow_waddr, w_pa_raddr, w_pb_raddr;
    logic [AW-1:0] w_scr_addr;
    logic [31:0]   w_pow_wdata;
    logic [31:0]   w_base_rd, w_pa_rd, w_pb_rd, w_scr_rd, w_sum;
    t_mac_ctl      w_mac;

    function automatic logic [AW-1:0] f_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
        return AW'(int'(r) * MAX_DIM + int'(c));
    endfunction

    always_comb begin
        if (r_mdim == '0) begin
            w_d = CW'(1);
        end else if (int'(r_mdim) > MAX_DIM) begin
            w_d = CW'(MAX_DIM);
        end else begin
            w_d = CW'(r_mdim);
        end
    end

    assign w_dm1     = w_d - 1'b1;
    assign w_total   = LW'(int'(w_d) * int'(w_d));
    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = r_out_valid && !i_out_stall;
    assign w_last_ij = (r_i == w_dm1) && (r_j == w_dm1);

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_val;
    assign o_result_last  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mdim  <= DIM_RESET;
            r_power <= POWER_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_MATRIX_DIM) begin
                r_mdim <= i_cfg_data[DIMREG_W-1:0];
            end else if (i_cfg_index == CFG_POWER) begin
                r_power <= i_cfg_data;
            end
        end
    end

    // load side: row/col counters follow load_count
    assign w_base_we    = w_in_acc && (r_lcnt < w_total);
    assign w_base_waddr = f_addr(r_lr, r_lc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcnt <= '0;
            r_lr   <= '0;
            r_lc   <= '0;
        end else if (w_in_acc) begin
            if (i_last_element) begin
                r_lcnt <= '0;
                r_lr   <= '0;
                r_lc   <= '0;
            end else if (w_base_we) begin
                r_lcnt <= r_lcnt + 1'b1;
                if (r_lc == w_dm1) begin
                    r_lc <= '0;
                    r_lr <= r_lr + 1'b1;
                end else begin
                    r_lc <= r_lc + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_last_element) begin
            r_e <= r_power;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bit   <= '0;
            r_sq    <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
            r_sq    <= n_sq;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_bit        = r_bit;
        n_sq         = r_sq;
        n_i          = r_i;
        n_j          = r_j;
        n_k          = r_k;
        w_base_raddr = f_addr(r_i, r_j);
        w_pa_raddr   = f_addr(r_i, r_j);
        w_pb_raddr   = f_addr(r_k, r_j);
        w_pow_we     = 1'b0;
        w_pow_waddr  = f_addr(r_i, r_j);
        w_pow_wdata  = w_base_rd;
        w_scr_we     = 1'b0;
        w_scr_addr   = f_addr(r_i, r_j);
        w_mac        = '0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_last_element) begin
                    n_i   = '0;
                    n_j   = '0;
                    n_k   = '0;
                    n_bit = 4'd15;
                    n_state = (r_power == '0) ? S_EMIT_RD : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_e[r_bit]) begin
                    n_state = S_INIT_RD;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            S_INIT_RD: begin
                n_state = S_INIT_WR;
            end
            S_INIT_WR: begin
                w_pow_we = 1'b1;
                n_state  = S_INIT_RD;
                if (r_j == w_dm1) begin
                    n_j = '0;
                    n_i = r_i + 1'b1;
                end else begin
                    n_j = r_j + 1'b1;
                end
                if (w_last_ij) begin
                    n_i = '0;
                    if (r_bit == '0) begin
                        n_state = S_EMIT_RD;
                    end else begin
                        n_bit   = r_bit - 1'b1;
                        n_sq    = 1'b1;
                        n_state = S_MUL_RD;
                    end
                end
            end
            S_MUL_RD: begin
                w_base_raddr = f_addr(r_i, r_k);
                w_pa_raddr   = f_addr(r_i, r_k);
                n_state      = S_MUL_PROD;
            end
            S_MUL_PROD: begin
                w_mac.mul_en = 1'b1;
                n_state      = S_MUL_ACC;
            end
            S_MUL_ACC: begin
                w_mac.acc_en = 1'b1;
                n_state      = S_MUL_RD;
                if (r_k == w_dm1) begin
                    // element done: store the sum and restart the accumulator
                    w_mac.clr = 1'b1;
                    w_scr_we  = 1'b1;
                    n_k       = '0;
                    if (r_j == w_dm1) begin
                        n_j = '0;
                        n_i = r_i + 1'b1;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                    if (w_last_ij) begin
                        n_i     = '0;
                        n_state = S_CPY_RD;
                    end
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_CPY_RD: begin
                n_state = S_CPY_WR;
            end
            S_CPY_WR: begin
                w_pow_we    = 1'b1;
                w_pow_wdata = w_scr_rd;
                n_state     = S_CPY_RD;
                if (r_j == w_dm1) begin
                    n_j = '0;
                    n_i = r_i + 1'b1;
                end else begin
                    n_j = r_j + 1'b1;
                end
                if (w_last_ij) begin
                    n_i = '0;
                    if (r_sq && r_e[r_bit]) begin
                        n_sq    = 1'b0;
                        n_state = S_MUL_RD;
                    end else if (r_bit == '0) begin
                        n_state = S_EMIT_RD;
                    end else begin
                        n_bit   = r_bit - 1'b1;
                        n_sq    = 1'b1;
                        n_state = S_MUL_RD;
                    end
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LOAD;
            end
            S_EMIT_LOAD: begin
                n_state = S_EMIT_HOLD;
            end
            S_EMIT_HOLD: begin
                if (w_out_acc) begin
                    n_state = S_EMIT_RD;
                    if (r_j == w_dm1) begin
                        n_j = '0;
                        n_i = r_i + 1'b1;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                    if (w_last_ij) begin
                        n_i     = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT_LOAD) begin
            if (r_e == '0) begin
                r_out_val <= (r_i == r_j) ? 32'd1 : 32'd0;
            end else begin
                r_out_val <= w_pa_rd;
            end
            r_out_last <= w_last_ij;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT_LOAD) begin
            r_out_valid <= 1'b1;
        end else if (w_out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    mps_ram #(.WIDTH(32), .DEPTH(CELLS)) u_base (
        .i_clk   (i_clk),
        .i_we    (w_base_we),
        .i_waddr (w_base_waddr),
        .i_wdata (i_element_value),
        .i_raddr (w_base_raddr),
        .o_rdata (w_base_rd)
    );

    // running power kept twice so both operands of a square read in the same cycle
    mps_ram #(.WIDTH(32), .DEPTH(CELLS)) u_pow_a (
        .i_clk   (i_clk),
        .i_we    (w_pow_we),
        .i_waddr (w_pow_waddr),
        .i_wdata (w_pow_wdata),
        .i_raddr (w_pa_raddr),
        .o_rdata (w_pa_rd)
    );

    mps_ram #(.WIDTH(32), .DEPTH(CELLS)) u_pow_b (
        .i_clk   (i_clk),
        .i_we    (w_pow_we),
        .i_waddr (w_pow_waddr),
        .i_wdata (w_pow_wdata),
        .i_raddr (w_pb_raddr),
        .o_rdata (w_pb_rd)
    );

    mps_ram #(.WIDTH(32), .DEPTH(CELLS)) u_scratch (
        .i_clk   (i_clk),
        .i_we    (w_scr_we),
        .i_waddr (w_scr_addr),
        .i_wdata (w_sum),
        .i_raddr (w_scr_addr),
        .o_rdata (w_scr_rd)
    );

    mps_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac),
        .i_a     (r_sq ? w_pa_rd : w_base_rd),
        .i_b     (w_pb_rd),
        .o_sum   (w_sum)
    );

    a_idle_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_out_valid)
        else $error("result beat pending while idle");

    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_last_element) |=> o_in_stall)
        else $error("last element did not start the computation");

    a_last_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_result_last) |=> !o_in_stall)
        else $error("block not idle after final result beat");

    a_mac_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scr_we |-> (r_state == S_MUL_ACC && r_k == w_dm1))
        else $error("scratch written outside an element end");

endmodule
